>>> design/sed_pkg.sv
package sed_pkg;

   // Input transaction: one raw content byte of a string literal
   typedef struct packed {
      logic [7:0] content_byte;
      logic       last_byte;
   } req_type;

   // Output transaction: a decoded byte or the string's final status
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       run_end;
   } rsp_type;

   // Result kinds
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Everything one input byte produces: up to four UTF-8 bytes and a status
   localparam int MAX_BYTES = 4;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] byte_seq;
      logic [2:0]                byte_count;
      logic                      has_status;
      logic                      reject;
   } job_type;

   // Default depth of the queue between classifier and emitter
   localparam int QUEUE_DEPTH_DEF = 4;

endpackage

>>> design/string_escape_utf8_decoder_top.sv
// The first result of a byte is registered in the job queue, then in the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and
// rsp_stall is low; the emitter sends one result per cycle while rsp_stall is low, and
// the job queue (QUEUE_DEPTH, 4 by default) absorbs UTF-8 bursts before req_stall rises.
// Reset: synchronous, active high; returns the decoder to plain text and empties queue
// and output register.
module string_escape_utf8_decoder_top #(
   parameter int QUEUE_DEPTH = sed_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sed_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sed_pkg::rsp_type rsp_data
);
   import sed_pkg::*;

   logic    accept;
   logic    job_push;
   job_type job;
   logic    q_full;
   logic    head_valid;
   job_type head_job;
   logic    pop;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Classifier
   sed_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .job_push (job_push),
      .job      (job)
   );

   // Job queue
   sed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (q_full)
   );

   // Result emitter
   sed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef SYNTHESIS
   // A status transaction always closes the run of its input byte
   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_DATA |-> rsp_data.run_end)
      else $error("status transaction without run_end");

   // Status transactions carry a zero data byte
   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_DATA |-> rsp_data.data_byte == 8'd0)
      else $error("status transaction with nonzero data byte");

   // Input is only held off while queued work is pending
   a_stall_has_work: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> head_valid)
      else $error("input stalled with an empty queue");

   // A popped job's last result is in the output register in the cycle after the pop
   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid && rsp_data.run_end)
      else $error("job retired without a run_end transaction");
`endif

endmodule

>>> design/sed_front.sv
module sed_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  sed_pkg::req_type req_data,
   output logic            job_push,
   output sed_pkg::job_type job
);
   import sed_pkg::*;

   typedef enum logic [2:0] {
      M_PLAIN = 3'd0,
      M_ESC   = 3'd1,
      M_HEX2  = 3'd2,
      M_BRACE = 3'd3,
      M_UNI   = 3'd4,
      M_ERROR = 3'd5
   } mode_type;

   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_U      = 8'h75;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [24:0] CODE_MAX = 25'h10FFFF;

   mode_type    mode_ff, mode_in;
   logic [20:0] acc_ff, acc_in;
   logic        big_ff, big_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic [7:0]  b;
   logic        last;
   logic        dig_ok;
   logic [3:0]  dig;
   logic [1:0]  cnt_inc;
   logic [24:0] shifted;
   job_type     job_c;

   // Hex digit classification
   always_comb begin
      dig_ok = 1'b1;
      dig    = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         dig = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         dig = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         dig = 4'(b - 8'h37);
      end else begin
         dig_ok = 1'b0;
      end
   end

   assign b       = req_data.content_byte;
   assign last    = req_data.last_byte;
   assign cnt_inc = cnt_ff + 2'd1;
   assign shifted = {acc_ff, dig};

   // Decode step: next state and the results this byte produces
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      big_in  = big_ff;
      cnt_in  = cnt_ff;
      job_c   = '0;
      case (mode_ff)
         M_PLAIN: begin
            if (b == CH_BSLASH && !last) begin
               mode_in = M_ESC;
            end else begin
               job_c.byte_seq[0] = b;
               job_c.byte_count  = 3'd1;
            end
         end
         M_ESC: begin
            mode_in = M_PLAIN;
            case (b)
               CH_N: begin
                  job_c.byte_seq[0] = 8'h0A;
                  job_c.byte_count  = 3'd1;
               end
               CH_T: begin
                  job_c.byte_seq[0] = 8'h09;
                  job_c.byte_count  = 3'd1;
               end
               CH_R: begin
                  job_c.byte_seq[0] = 8'h0D;
                  job_c.byte_count  = 3'd1;
               end
               CH_ZERO: begin
                  job_c.byte_seq[0] = 8'h00;
                  job_c.byte_count  = 3'd1;
               end
               CH_BSLASH, CH_DQUOTE, CH_SQUOTE: begin
                  job_c.byte_seq[0] = b;
                  job_c.byte_count  = 3'd1;
               end
               CH_X: begin
                  mode_in = M_HEX2;
                  acc_in  = '0;
                  cnt_in  = '0;
               end
               CH_U: begin
                  mode_in = M_BRACE;
               end
               default: begin
                  mode_in = M_ERROR;
               end
            endcase
         end
         M_HEX2: begin
            if (!dig_ok) begin
               mode_in = M_ERROR;
            end else begin
               acc_in = {13'd0, acc_ff[3:0], dig};
               cnt_in = cnt_inc;
               // second digit completes the raw byte
               if (cnt_inc[1]) begin
                  job_c.byte_seq[0] = {acc_ff[3:0], dig};
                  job_c.byte_count  = 3'd1;
                  mode_in = M_PLAIN;
                  acc_in  = '0;
                  cnt_in  = '0;
               end
            end
         end
         M_BRACE: begin
            if (b == CH_LBRACE) begin
               mode_in = M_UNI;
               acc_in  = '0;
               big_in  = 1'b0;
               cnt_in  = '0;
            end else begin
               mode_in = M_ERROR;
            end
         end
         M_UNI: begin
            if (b == CH_RBRACE) begin
               if (cnt_ff == 2'd0 || big_ff) begin
                  mode_in = M_ERROR;
               end else begin
                  mode_in = M_PLAIN;
                  // UTF-8 encode of the gathered code point
                  if (acc_ff <= 21'h7F) begin
                     job_c.byte_seq[0] = acc_ff[7:0];
                     job_c.byte_count  = 3'd1;
                  end else if (acc_ff <= 21'h7FF) begin
                     job_c.byte_seq[0] = {3'b110, acc_ff[10:6]};
                     job_c.byte_seq[1] = {2'b10, acc_ff[5:0]};
                     job_c.byte_count  = 3'd2;
                  end else if (acc_ff <= 21'hFFFF) begin
                     job_c.byte_seq[0] = {4'b1110, acc_ff[15:12]};
                     job_c.byte_seq[1] = {2'b10, acc_ff[11:6]};
                     job_c.byte_seq[2] = {2'b10, acc_ff[5:0]};
                     job_c.byte_count  = 3'd3;
                  end else begin
                     job_c.byte_seq[0] = {5'b11110, acc_ff[20:18]};
                     job_c.byte_seq[1] = {2'b10, acc_ff[17:12]};
                     job_c.byte_seq[2] = {2'b10, acc_ff[11:6]};
                     job_c.byte_seq[3] = {2'b10, acc_ff[5:0]};
                     job_c.byte_count  = 3'd4;
                  end
               end
               acc_in = '0;
               big_in = 1'b0;
               cnt_in = '0;
            end else if (!dig_ok) begin
               mode_in = M_ERROR;
            end else begin
               if (shifted > CODE_MAX) begin
                  big_in = 1'b1;
               end
               acc_in = shifted[20:0];
               cnt_in = 2'd1;
            end
         end
         default: begin
            mode_in = M_ERROR;
         end
      endcase

      // End of string: status and return to plain text
      if (last) begin
         job_c.has_status = 1'b1;
         job_c.reject     = (mode_in != M_PLAIN);
         mode_in = M_PLAIN;
         acc_in  = '0;
         big_in  = 1'b0;
         cnt_in  = '0;
      end
   end

   assign job      = job_c;
   assign job_push = accept && (job_c.byte_count != 3'd0 || job_c.has_status);

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_PLAIN;
         acc_ff  <= '0;
         big_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         big_ff  <= big_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

>>> design/sed_queue.sv
module sed_queue #(
   parameter int DEPTH = sed_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sed_pkg::job_type push_job,
   input  logic             pop,
   output logic             head_valid,
   output sed_pkg::job_type head_job,
   output logic             full
);
   import sed_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   job_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full       = (cnt_ff == CNT_FULL);
   assign head_valid = (cnt_ff != '0);
   assign head_job   = mem[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_job;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_ONE;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_ONE;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + CNT_ONE;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - CNT_ONE;
         end
      end
   end

endmodule

>>> design/sed_back.sv
module sed_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  sed_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sed_pkg::rsp_type rsp_data
);
   import sed_pkg::*;

   logic [2:0] idx_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;
   logic [2:0] total_m1;
   logic       at_end;
   logic       load;
   rsp_type    next_rsp;

   // Position of the current result inside the head job
   assign total_m1 = 3'(head_job.byte_count + {2'd0, head_job.has_status} - 3'd1);
   assign at_end   = (idx_ff == total_m1);
   assign load     = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop      = load && at_end;

   // Select the data byte or the closing status
   always_comb begin
      next_rsp = '0;
      if (idx_ff < head_job.byte_count) begin
         next_rsp.kind      = KIND_DATA;
         next_rsp.data_byte = head_job.byte_seq[idx_ff[1:0]];
      end else begin
         next_rsp.kind = head_job.reject ? KIND_REJECT : KIND_ACCEPT;
      end
      next_rsp.run_end = at_end;
   end

   // Output register and result index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         idx_ff       <= at_end ? 3'd0 : idx_ff + 3'd1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= next_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
